[rtl/hrp_pkg.sv]
// Shared types, constants and matcher functions for the HTTP request byte parser.
// No dependencies; every other file uses this package.
package hrp_pkg;

    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int VERSION_WIDTH_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;

    // byte classes
    localparam logic [2:0] CLS_FRAMING = 3'd0;
    localparam logic [2:0] CLS_METHOD  = 3'd1;
    localparam logic [2:0] CLS_URL     = 3'd2;
    localparam logic [2:0] CLS_HNAME   = 3'd3;
    localparam logic [2:0] CLS_HVALUE  = 3'd4;
    localparam logic [2:0] CLS_BODY    = 3'd5;

    // status codes
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // method codes
    localparam logic [2:0] MC_GET    = 3'd0;
    localparam logic [2:0] MC_POST   = 3'd1;
    localparam logic [2:0] MC_PUT    = 3'd2;
    localparam logic [2:0] MC_DELETE = 3'd3;
    localparam logic [2:0] MC_OTHER  = 3'd4;

    // header kinds
    localparam logic [1:0] HDR_NONE = 2'd0;
    localparam logic [1:0] HDR_CLEN = 2'd1;
    localparam logic [1:0] HDR_TENC = 2'd2;
    localparam logic [1:0] HDR_CONN = 2'd3;

    // characters
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [14*8-1:0] HN_CLEN = "content-length";
    localparam logic [17*8-1:0] HN_TENC = "transfer-encoding";
    localparam logic [10*8-1:0] HN_CONN = "connection";
    localparam logic [7*8-1:0]  HV_CHUNKED = "chunked";
    localparam logic [10*8-1:0] HV_KEEP    = "keep-alive";
    localparam logic [5*8-1:0]  VER_TEXT   = "HTTP/";

    localparam logic [7:0] TRIE_CH [16] = '{8'h00, "E", "T", 8'h00, "O", "S", "T", 8'h00,
                                            "T", 8'h00, "E", "L", "E", "T", "E", 8'h00};
    localparam logic [3:0] TRIE_NX [16] = '{4'd0, 4'd2, 4'd3, 4'd0, 4'd5, 4'd6, 4'd7, 4'd0,
                                            4'd9, 4'd0, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
                                            4'd0};

    typedef enum logic [4:0] {
        PH_MSTART, PH_METHOD, PH_USTART, PH_URL, PH_VH, PH_VHT, PH_VHTT, PH_VHTTP,
        PH_VSLASH, PH_MAJ0, PH_MAJ, PH_MIN0, PH_MIN, PH_HLF, PH_LINE, PH_LWS,
        PH_NAME, PH_SP, PH_VSTART, PH_VALUE, PH_ENDLF, PH_BODY, PH_CSIZE, PH_CEXT,
        PH_CRONLY, PH_CSLF, PH_CZERO, PH_CFINAL, PH_TNAME, PH_CDATA, PH_CDCR, PH_CDLF
    } t_phase;

    // pre-classified request byte, as queued between front and back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lc;
        logic       start;
        logic       tok;
        logic       ctl;
        logic       dig;
        logic       alpha;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_qent;

    typedef struct packed {
        logic have;
        logic conn;
        logic keep;
        logic chunk;
        logic done;
        logic err;
    } t_flags;

    function automatic logic [4:0] hdr_len(logic [1:0] cand);
        logic [4:0] l;
        unique case (cand)
            HDR_CLEN: l = 5'd14;
            HDR_TENC: l = 5'd17;
            HDR_CONN: l = 5'd10;
            default:  l = 5'd0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] name_char(logic [1:0] cand, logic [4:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (cand)
            HDR_CLEN: if (pos < 5'd14) ch = HN_CLEN[8*(13-int'(pos)) +: 8];
            HDR_TENC: if (pos < 5'd17) ch = HN_TENC[8*(16-int'(pos)) +: 8];
            HDR_CONN: if (pos < 5'd10) ch = HN_CONN[8*(9-int'(pos)) +: 8];
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] value_char(logic [1:0] kind, logic [4:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (kind == HDR_TENC) begin
            if (pos < 5'd7) ch = HV_CHUNKED[8*(6-int'(pos)) +: 8];
        end else if (pos < 5'd10) begin
            ch = HV_KEEP[8*(9-int'(pos)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [6:0] name_next(logic first, logic [6:0] nm, logic [7:0] lc);
        logic [1:0] cand;
        logic [4:0] pos;
        logic [6:0] r;
        r    = '0;
        cand = nm[6:5];
        pos  = nm[4:0];
        if (first) begin
            if (lc == "c")      r = {HDR_CLEN, 5'd1};
            else if (lc == "t") r = {HDR_TENC, 5'd1};
        end else if (cand != HDR_NONE) begin
            // "con" branches to connection on 'n'
            if (cand == HDR_CLEN && pos == 5'd3 && lc == "n") cand = HDR_CONN;
            if (pos < hdr_len(cand) && name_char(cand, pos) == lc) r = {cand, pos + 5'd1};
        end
        return r;
    endfunction

    function automatic logic [3:0] trie_next(logic first, logic [3:0] st, logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        if (first) begin
            if (c == "G")      r = 4'd1;
            else if (c == "P") r = 4'd4;
            else if (c == "D") r = 4'd10;
        end else if (st == 4'd4 && c == "U") begin
            r = 4'd8;
        end else if (TRIE_CH[st] != 8'h00 && TRIE_CH[st] == c) begin
            r = TRIE_NX[st];
        end
        return r;
    endfunction

    function automatic logic [2:0] method_code_of(logic [3:0] st);
        logic [2:0] m;
        unique case (st)
            4'd3:    m = MC_GET;
            4'd7:    m = MC_POST;
            4'd9:    m = MC_PUT;
            4'd15:   m = MC_DELETE;
            default: m = MC_OTHER;
        endcase
        return m;
    endfunction

endpackage

[rtl/hrp_if.sv]
// Valid/ready channel interfaces for request bytes and tagged result bytes.
// Depends on hrp_pkg for the default field widths.
interface hrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, data_byte, start_req, input ready);
    modport sink   (input valid, data_byte, start_req, output ready);
endinterface

interface hrp_res_if #(
    parameter int COUNT_WIDTH   = hrp_pkg::COUNT_WIDTH_DEF,
    parameter int VERSION_WIDTH = hrp_pkg::VERSION_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [7:0]               byte_echo;
    logic [2:0]               byte_class;
    logic                     field_first;
    logic [1:0]               status;
    logic [2:0]               method_code;
    logic [VERSION_WIDTH-1:0] version_major;
    logic [VERSION_WIDTH-1:0] version_minor;
    logic                     keep_alive;
    logic                     is_chunked;
    logic [COUNT_WIDTH-1:0]   content_length;

    modport source (output valid, byte_echo, byte_class, field_first, status, method_code,
                    version_major, version_minor, keep_alive, is_chunked, content_length,
                    input ready);
    modport sink   (input valid, byte_echo, byte_class, field_first, status, method_code,
                    version_major, version_minor, keep_alive, is_chunked, content_length,
                    output ready);
endinterface

[rtl/hrp_front.sv]
// Front end: accepts request bytes and classifies each character.
// Depends on hrp_pkg and hrp_byte_if.
module hrp_front (
    hrp_byte_if.sink        i_req,
    input  logic            i_q_full,
    output logic            o_push,
    output hrp_pkg::t_qent  o_ent
);
    import hrp_pkg::*;

    logic [7:0] c;
    logic       sep;

    assign c = i_req.data_byte;
    assign i_req.ready = !i_q_full;
    assign o_push = i_req.valid && !i_q_full;

    always_comb begin
        unique case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
            "=", "{", "}", CH_SP, CH_HT: sep = 1'b1;
            default: sep = 1'b0;
        endcase
        o_ent.data    = c;
        o_ent.start   = i_req.start_req;
        o_ent.lc      = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        o_ent.ctl     = (c <= 8'd31) || (c == 8'd127);
        o_ent.tok     = !c[7] && !o_ent.ctl && !sep;
        o_ent.dig     = (c >= "0" && c <= "9");
        o_ent.alpha   = (o_ent.lc >= "a" && o_ent.lc <= "z");
        o_ent.hex_ok  = o_ent.dig || (o_ent.lc >= "a" && o_ent.lc <= "f");
        o_ent.hex_val = o_ent.dig ? c[3:0] : 4'(o_ent.lc - "a" + 8'd10);
    end

endmodule

[rtl/hrp_queue.sv]
// Short queue of classified bytes between the front end and the parser.
// Depends on hrp_pkg.
module hrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hrp_pkg::t_qent  i_ent,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output hrp_pkg::t_qent  o_ent
);
    import hrp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_qent             r_mem [QUEUE_DEPTH];
    logic [AW-1:0]     r_wp, n_wp, r_rp, n_rp;
    logic [AW:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? ((r_wp == AW'(QUEUE_DEPTH-1)) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp  = i_pop  ? ((r_rp == AW'(QUEUE_DEPTH-1)) ? '0 : r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) r_mem[r_wp] <= i_ent;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0) else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_cnt == $past(r_cnt) + 1'b1) else $error("push lost");

endmodule

[rtl/hrp_back.sv]
// Back end: request parser state machine, matchers, counters and result register.
// Depends on hrp_pkg, hrp_queue output and hrp_res_if.
module hrp_back #(
    parameter int COUNT_WIDTH   = hrp_pkg::COUNT_WIDTH_DEF,
    parameter int VERSION_WIDTH = hrp_pkg::VERSION_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  hrp_pkg::t_qent  i_ent,
    output logic            o_pop,
    hrp_res_if.source       o_res
);
    import hrp_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int VW = VERSION_WIDTH;

    function automatic logic [CW-1:0] cnt_acc(logic [CW-1:0] v, logic [3:0] d, logic hex);
        logic [CW+3:0] w;
        w = hex ? {v, 4'b0} : ({1'b0, v, 3'b0} + {3'b0, v, 1'b0});
        w = w + (CW+4)'(d);
        return (w[CW+3:CW] != 4'd0) ? '1 : w[CW-1:0];
    endfunction

    function automatic logic [VW-1:0] ver_acc(logic [VW-1:0] v, logic [3:0] d);
        logic [VW+3:0] w;
        w = ({1'b0, v, 3'b0} + {3'b0, v, 1'b0}) + (VW+4)'(d);
        return (w[VW+3:VW] != 4'd0) ? '1 : w[VW-1:0];
    endfunction

    t_phase        r_phase, n_phase, cur_phase;
    logic [3:0]    r_meth, n_meth, cur_meth;
    logic [6:0]    r_name, n_name, cur_name;
    logic [4:0]    r_vm, n_vm, cur_vm;
    logic [VW-1:0] r_maj, n_maj, cur_maj;
    logic [VW-1:0] r_min, n_min, cur_min;
    logic [CW-1:0] r_len, n_len, cur_len;
    logic [CW-1:0] r_vn, n_vn, cur_vn;
    logic [CW-1:0] r_rem, n_rem, cur_rem;
    t_flags        r_flags, n_flags, cur_flags;

    logic [1:0]    kind;
    logic [4:0]    vf_vm, hx_vm;
    logic [CW-1:0] vf_vn, hx_vn;
    logic [7:0]    c;
    logic [2:0]    cls;
    logic          first, err;
    logic          ka;

    logic            r_out_valid;
    logic [7:0]      r_echo;
    logic [2:0]      r_cls;
    logic            r_first;
    logic [1:0]      r_status;
    logic [2:0]      r_mcode;
    logic            r_ka;

    assign o_pop = i_q_valid && (!r_out_valid || o_res.ready);
    assign c     = i_ent.data;

    always_comb begin
        cur_phase = i_ent.start ? PH_MSTART : r_phase;
        cur_meth  = i_ent.start ? '0 : r_meth;
        cur_name  = i_ent.start ? '0 : r_name;
        cur_vm    = i_ent.start ? '0 : r_vm;
        cur_maj   = i_ent.start ? '0 : r_maj;
        cur_min   = i_ent.start ? '0 : r_min;
        cur_len   = i_ent.start ? '0 : r_len;
        cur_vn    = i_ent.start ? '0 : r_vn;
        cur_rem   = i_ent.start ? '0 : r_rem;
        cur_flags = i_ent.start ? '0 : r_flags;
    end

    // header value matcher and decimal length reader
    always_comb begin
        kind = (cur_name[6:5] != HDR_NONE && cur_name[4:0] == hdr_len(cur_name[6:5]))
             ? cur_name[6:5] : HDR_NONE;
        vf_vm = cur_vm;
        vf_vn = cur_vn;
        if (kind == HDR_CLEN) begin
            if (cur_vm == 5'd0 && c == CH_SP) begin
                vf_vm = cur_vm;
            end else if (cur_vm == 5'd0 && c == CH_PLUS) begin
                vf_vm = 5'd1;
            end else if (cur_vm <= 5'd2 && i_ent.dig) begin
                vf_vn = cnt_acc(cur_vn, c[3:0], 1'b0);
                vf_vm = 5'd2;
            end else begin
                vf_vm = 5'd3;
            end
        end else if (kind != HDR_NONE) begin
            if (cur_vm < ((kind == HDR_TENC) ? 5'd7 : 5'd10) &&
                value_char(kind, cur_vm) == i_ent.lc)
                vf_vm = cur_vm + 5'd1;
            else
                vf_vm = 5'd31;
        end
    end

    // chunk size reader: 0 empty, 1 stopped, 2 digits, 3 lone zero, 4 after 0x
    always_comb begin
        hx_vm = cur_vm;
        hx_vn = cur_vn;
        if (cur_vm != 5'd1) begin
            if (i_ent.hex_ok) begin
                if (cur_vm == 5'd0 && c == CH_ZERO) begin
                    hx_vm = 5'd3;
                end else begin
                    hx_vn = cnt_acc(cur_vn, i_ent.hex_val, 1'b1);
                    hx_vm = 5'd2;
                end
            end else begin
                hx_vm = (cur_vm == 5'd3 && i_ent.lc == CH_LX) ? 5'd4 : 5'd1;
            end
        end
    end

    always_comb begin
        n_phase = cur_phase;
        n_meth  = cur_meth;
        n_name  = cur_name;
        n_vm    = cur_vm;
        n_maj   = cur_maj;
        n_min   = cur_min;
        n_len   = cur_len;
        n_vn    = cur_vn;
        n_rem   = cur_rem;
        n_flags = cur_flags;
        cls     = CLS_FRAMING;
        first   = 1'b0;
        err     = 1'b0;
        if (!(cur_flags.done || cur_flags.err)) begin
            unique case (cur_phase)
                PH_MSTART: begin
                    if (i_ent.tok) begin
                        n_meth = trie_next(1'b1, 4'd0, c);
                        cls = CLS_METHOD;
                        first = 1'b1;
                        n_phase = PH_METHOD;
                    end else err = 1'b1;
                end
                PH_METHOD: begin
                    if (c == CH_SP) n_phase = PH_USTART;
                    else if (i_ent.tok) begin
                        n_meth = trie_next(1'b0, cur_meth, c);
                        cls = CLS_METHOD;
                    end else err = 1'b1;
                end
                PH_USTART: begin
                    if (i_ent.ctl) err = 1'b1;
                    else begin
                        cls = CLS_URL;
                        first = 1'b1;
                        n_phase = PH_URL;
                    end
                end
                PH_URL: begin
                    if (c == CH_SP) n_phase = PH_VH;
                    else if (c == CH_CR) begin
                        // HTTP/0.9 request line
                        n_maj = '0;
                        n_min = VW'(9);
                        n_flags.done = 1'b1;
                    end else if (i_ent.ctl) err = 1'b1;
                    else cls = CLS_URL;
                end
                PH_VH, PH_VHT, PH_VHTT, PH_VHTTP, PH_VSLASH: begin
                    if (c == VER_TEXT[8*(4 - int'(cur_phase - PH_VH)) +: 8]) begin
                        if (cur_phase == PH_VSLASH) begin
                            n_maj = '0;
                            n_min = '0;
                        end
                        n_phase = t_phase'(cur_phase + 5'd1);
                    end else err = 1'b1;
                end
                PH_MAJ0: begin
                    if (i_ent.dig) begin
                        n_maj = ver_acc('0, c[3:0]);
                        n_phase = PH_MAJ;
                    end else err = 1'b1;
                end
                PH_MAJ: begin
                    if (c == CH_DOT) n_phase = PH_MIN0;
                    else if (i_ent.dig) n_maj = ver_acc(cur_maj, c[3:0]);
                    else err = 1'b1;
                end
                PH_MIN0: begin
                    if (i_ent.dig) begin
                        n_min = ver_acc('0, c[3:0]);
                        n_phase = PH_MIN;
                    end else err = 1'b1;
                end
                PH_MIN: begin
                    if (c == CH_CR) n_phase = PH_HLF;
                    else if (i_ent.dig) n_min = ver_acc(cur_min, c[3:0]);
                    else err = 1'b1;
                end
                PH_HLF: begin
                    if (c == CH_LF) n_phase = PH_LINE;
                    else err = 1'b1;
                end
                PH_LINE: begin
                    if (c == CH_CR) n_phase = PH_ENDLF;
                    else if (cur_flags.have && (c == CH_SP || c == CH_HT)) n_phase = PH_LWS;
                    else if (!i_ent.tok) err = 1'b1;
                    else begin
                        n_name = name_next(1'b1, 7'd0, i_ent.lc);
                        n_vm = '0;
                        n_vn = '0;
                        cls = CLS_HNAME;
                        first = 1'b1;
                        n_phase = PH_NAME;
                    end
                end
                PH_LWS: begin
                    if (c == CH_CR) n_phase = PH_HLF;
                    else if (c == CH_SP || c == CH_HT) n_phase = PH_LWS;
                    else if (i_ent.ctl) err = 1'b1;
                    else begin
                        n_vm = vf_vm;
                        n_vn = vf_vn;
                        cls = CLS_HVALUE;
                        n_phase = PH_VALUE;
                    end
                end
                PH_NAME: begin
                    if (c == CH_COLON) n_phase = PH_SP;
                    else if (!i_ent.tok) err = 1'b1;
                    else begin
                        n_name = name_next(1'b0, cur_name, i_ent.lc);
                        cls = CLS_HNAME;
                    end
                end
                PH_SP: begin
                    if (c == CH_SP) n_phase = PH_VSTART;
                    else err = 1'b1;
                end
                PH_VSTART, PH_VALUE: begin
                    if (c == CH_CR) begin
                        n_flags.have = 1'b1;
                        if (kind == HDR_CONN) begin
                            n_flags.conn = 1'b1;
                            n_flags.keep = (cur_vm == 5'd10);
                        end
                        if (method_code_of(cur_meth) == MC_POST ||
                            method_code_of(cur_meth) == MC_PUT ||
                            method_code_of(cur_meth) == MC_DELETE) begin
                            if (kind == HDR_CLEN) n_len = cur_vn;
                            if (kind == HDR_TENC && cur_vm == 5'd7) n_flags.chunk = 1'b1;
                        end
                        n_phase = PH_HLF;
                    end else if (i_ent.ctl) err = 1'b1;
                    else begin
                        n_vm = vf_vm;
                        n_vn = vf_vn;
                        cls = CLS_HVALUE;
                        first = (cur_phase == PH_VSTART);
                        n_phase = PH_VALUE;
                    end
                end
                PH_ENDLF: begin
                    if (c != CH_LF) err = 1'b1;
                    else if (cur_flags.chunk) begin
                        n_vn = '0;
                        n_vm = '0;
                        n_phase = PH_CSIZE;
                    end else if (cur_len == '0) n_flags.done = 1'b1;
                    else begin
                        n_rem = cur_len;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    cls = CLS_BODY;
                    if (cur_rem <= CW'(1)) begin
                        n_rem = '0;
                        n_flags.done = 1'b1;
                    end else n_rem = cur_rem - 1'b1;
                end
                PH_CSIZE: begin
                    if (i_ent.alpha || i_ent.dig) begin
                        n_vm = hx_vm;
                        n_vn = hx_vn;
                    end else if (c == CH_SEMI) n_phase = PH_CEXT;
                    else if (c == CH_CR) n_phase = PH_CSLF;
                    else err = 1'b1;
                end
                PH_CEXT: begin
                    if (c == CH_EQ) n_phase = PH_CRONLY;
                    else if (c == CH_CR) n_phase = PH_CSLF;
                    else err = 1'b1;
                end
                PH_CRONLY: begin
                    if (c == CH_CR) n_phase = PH_CSLF;
                    else err = 1'b1;
                end
                PH_CSLF: begin
                    if (c != CH_LF) err = 1'b1;
                    else begin
                        n_vn = '0;
                        n_vm = '0;
                        if (cur_vn == '0) n_phase = PH_CZERO;
                        else begin
                            n_rem = cur_vn;
                            n_phase = PH_CDATA;
                        end
                    end
                end
                PH_CZERO: begin
                    if (c == CH_CR) n_phase = PH_CFINAL;
                    else if (i_ent.alpha) n_phase = PH_TNAME;
                    else err = 1'b1;
                end
                PH_CFINAL: begin
                    if (c == CH_LF) n_flags.done = 1'b1;
                    else err = 1'b1;
                end
                PH_TNAME: begin
                    if (c == CH_COLON) n_phase = PH_CRONLY;
                    else err = 1'b1;
                end
                PH_CDATA: begin
                    cls = CLS_BODY;
                    if (cur_rem <= CW'(1)) begin
                        n_rem = '0;
                        n_phase = PH_CDCR;
                    end else n_rem = cur_rem - 1'b1;
                end
                PH_CDCR: begin
                    if (c == CH_CR) n_phase = PH_CDLF;
                    else err = 1'b1;
                end
                PH_CDLF: begin
                    if (c == CH_LF) begin
                        n_vn = '0;
                        n_vm = '0;
                        n_phase = PH_CSIZE;
                    end else err = 1'b1;
                end
                default: err = 1'b1;
            endcase
            if (err) begin
                n_flags.err = 1'b1;
                cls = CLS_FRAMING;
                first = 1'b0;
            end
        end
        if (n_flags.conn) ka = n_flags.keep;
        else ka = (n_maj > VW'(1)) || (n_maj == VW'(1) && n_min >= VW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MSTART;
            r_meth      <= '0;
            r_name      <= '0;
            r_vm        <= '0;
            r_maj       <= '0;
            r_min       <= '0;
            r_len       <= '0;
            r_vn        <= '0;
            r_rem       <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_meth  <= n_meth;
                r_name  <= n_name;
                r_vm    <= n_vm;
                r_maj   <= n_maj;
                r_min   <= n_min;
                r_len   <= n_len;
                r_vn    <= n_vn;
                r_rem   <= n_rem;
                r_flags <= n_flags;
            end
            if (o_pop) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
        if (o_pop) begin
            r_echo   <= c;
            r_cls    <= cls;
            r_first  <= first;
            r_status <= n_flags.err ? ST_ERR : (n_flags.done ? ST_DONE : ST_BUSY);
            r_mcode  <= method_code_of(n_meth);
            r_ka     <= ka;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.byte_echo      = r_echo;
    assign o_res.byte_class     = r_cls;
    assign o_res.field_first    = r_first;
    assign o_res.status         = r_status;
    assign o_res.method_code    = r_mcode;
    assign o_res.version_major  = r_maj;
    assign o_res.version_minor  = r_min;
    assign o_res.keep_alive     = r_ka;
    assign o_res.is_chunked     = r_flags.chunk;
    assign o_res.content_length = r_len;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.err && !(o_pop && i_ent.start) |=> r_flags.err)
        else $error("error flag dropped without start");
    a_done_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flags.done && r_flags.err)) else $error("done and error both set");
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY && !r_flags.done |-> r_rem != '0)
        else $error("body phase with nothing remaining");

endmodule

[rtl/http_request_byte_parser_core.sv]
// Top level of the HTTP request byte parser: front classifier, queue, parser back end.
// Depends on hrp_pkg, hrp_if, hrp_front, hrp_queue and hrp_back.
//
// Usage: request bytes enter on i_req (data_byte, start_req) with valid/ready; each
// accepted byte yields exactly one tagged result on o_res: the byte echoed, its
// class, a field-start mark, the running status and the request summary (method,
// version, keep-alive, chunked, content length). Raise start_req with the first
// byte of a new request to clear all parse state before that byte is parsed.
// An accepted byte is written into the two-entry queue, then popped by the parser,
// which registers the result and raises o_res.valid; the classifier is combinational.
// Throughput is one byte per cycle while o_res.ready is high; the parser state
// machine updates once per byte and a two-entry queue decouples the classifier
// from the parser.
// When the receiver holds o_res.ready low the result register holds, the parser
// stalls, and the queue absorbs up to two more bytes before i_req.ready drops.
// Synchronous reset (i_rst_n low) empties the queue, drops o_res.valid and puts the
// parser at the start of a method.
module http_request_byte_parser_core #(
    parameter int COUNT_WIDTH   = hrp_pkg::COUNT_WIDTH_DEF,
    parameter int VERSION_WIDTH = hrp_pkg::VERSION_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrp_byte_if.sink  i_req,
    hrp_res_if.source o_res
);
    import hrp_pkg::*;

    logic  q_full;
    logic  q_push;
    logic  q_valid;
    logic  q_pop;
    t_qent q_in;
    t_qent q_out;

    hrp_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_ent    (q_in)
    );

    hrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_out)
    );

    hrp_back #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .VERSION_WIDTH (VERSION_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_ent     (q_out),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule
